// File: rtl/setx_pkg.sv
// Shared types, register indexes and decode constants for the sprite tile expander.
// No dependencies; imported by sprite_entry_tile_expander.
package setx_pkg;

   // sequencer states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   // configuration register indexes
   localparam logic [2:0] CSR_EXT_PRIORITY = 3'd0;
   localparam logic [2:0] CSR_EXT_BANKING  = 3'd1;
   localparam logic [2:0] CSR_WIDE_SCREEN  = 3'd2;
   localparam logic [2:0] CSR_X_OFFSET     = 3'd3;
   localparam logic [2:0] CSR_Y_OFFSET     = 3'd4;

   localparam int unsigned COORD_W = 13;
   localparam int unsigned CSR_DATA_W = 10;

   // layer priority masks
   localparam logic [15:0] PRI_MASK_LOW   = 16'hff00;
   localparam logic [15:0] PRI_MASK_MID   = 16'hffe0;
   localparam logic [15:0] PRI_MASK_HIGH  = 16'hfffc;
   localparam logic [15:0] PRI_MASK_TOP   = 16'hfffe;
   localparam logic [15:0] PRI_MASK_NONE  = 16'h0000;

   localparam logic [6:0] PALETTE_BASE = 7'h40;

   // decode the priority code into a layer mask
   function automatic logic [15:0] decode_priority(input logic ext_mode,
                                                    input logic bank_bit,
                                                    input logic [1:0] pri_code);
      logic [2:0] code;
      logic [15:0] mask;
      code = {bank_bit, pri_code};
      mask = PRI_MASK_NONE;
      if (ext_mode) begin
         unique case (code)
            3'd0, 3'd1: mask = PRI_MASK_LOW;
            3'd2, 3'd3: mask = PRI_MASK_HIGH;
            3'd4:       mask = PRI_MASK_MID;
            default:    mask = PRI_MASK_NONE;
         endcase
      end else begin
         mask = (pri_code == 2'd3) ? PRI_MASK_TOP : PRI_MASK_HIGH;
      end
      return mask;
   endfunction

endpackage

// File: rtl/sprite_entry_tile_expander.sv
// Sprite entry tile expander: one sprite list entry in, a grid of tile draw commands out.
// Depends on setx_pkg for states, register indexes and the priority decode.
//
// Usage:
//   req_*  : one four-word sprite entry per beat (attr, tile, x, y words).
//   rsp_*  : one tile draw command per beat, rsp_last marks the final tile
//            of the entry. Commands go column by column, rows inside.
//   csr_*  : register writes, index plus 10-bit data, always accepted.
//            Write only while the block is idle.
// Timing:
//   An enabled entry is loaded into the working registers, then the
//   output registers give one command per cycle while rsp_ready is high. A
//   disabled entry is accepted and produces nothing. A single position
//   stepper walks the grid by +/- TILE_SIZE per command, so the sequencer
//   handles one entry at a time and req_ready is low while it emits.
//   First command is visible the cycle after the entry beat.
// Reset:
//   Sequencer returns to idle, extended_priority = 0, extended_banking = 1,
//   wide_screen = 1, both offsets = 0.
// Backpressure:
//   With rsp_ready low the current command holds and the stepper waits.
module sprite_entry_tile_expander #(
   parameter int unsigned TILE_SIZE = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // entry channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [15:0]                   req_attr_word,
   input  logic [15:0]                   req_tile_word,
   input  logic [15:0]                   req_x_word,
   input  logic [15:0]                   req_y_word,
   // tile command channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_tile_code,
   output logic [6:0]                    rsp_palette_index,
   output logic                          rsp_flip_x,
   output logic                          rsp_flip_y,
   output logic signed [setx_pkg::COORD_W-1:0] rsp_draw_x,
   output logic signed [setx_pkg::COORD_W-1:0] rsp_draw_y,
   output logic [15:0]                   rsp_priority_mask,
   output logic                          rsp_last,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [setx_pkg::CSR_DATA_W-1:0] csr_data
);
   import setx_pkg::*;

   localparam logic signed [COORD_W-1:0] STEP = COORD_W'(TILE_SIZE);

   // configuration registers
   logic                         ext_pri_ff;
   logic                         ext_bank_ff;
   logic                         wide_ff;
   logic signed [CSR_DATA_W-1:0] x_off_ff;
   logic signed [CSR_DATA_W-1:0] y_off_ff;

   // sequencer and working registers
   state_type                  state_ff, state_in;
   logic [2:0]                 col_ff, col_in;
   logic [2:0]                 row_ff, row_in;
   logic [2:0]                 width_m1_ff, width_m1_in;
   logic [2:0]                 height_m1_ff, height_m1_in;
   logic [15:0]                code_ff, code_in;
   logic [6:0]                 palette_ff, palette_in;
   logic                       flip_x_ff, flip_x_in;
   logic                       flip_y_ff, flip_y_in;
   logic [15:0]                pmask_ff, pmask_in;
   logic signed [COORD_W-1:0]  pos_x_ff, pos_x_in;
   logic signed [COORD_W-1:0]  pos_y_ff, pos_y_in;
   logic signed [COORD_W-1:0]  y_start_ff, y_start_in;

   // entry decode
   logic                       req_beat;
   logic                       rsp_beat;
   logic                       cell_last_row;
   logic                       cell_last;
   logic signed [COORD_W-1:0]  x_ext, y_ext, x_off_ext, y_off_ext;
   logic signed [COORD_W-1:0]  span_x, span_y;
   logic signed [COORD_W-1:0]  y_first;
   logic [15:0]                base_code;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;
   assign cell_last_row = (row_ff == height_m1_ff);
   assign cell_last = cell_last_row && (col_ff == width_m1_ff);

   // sign-extend coordinates and offsets, form the spans, first row and base tile code
   always_comb begin
      if (wide_ff) begin
         x_ext = COORD_W'(signed'(req_x_word[11:0]));
         y_ext = COORD_W'(signed'(req_y_word[11:0]));
      end else begin
         x_ext = COORD_W'(signed'(req_x_word[8:0]));
         y_ext = COORD_W'(signed'(req_y_word[8:0]));
      end
      x_off_ext = COORD_W'(x_off_ff);
      y_off_ext = COORD_W'(y_off_ff);
      span_x = COORD_W'({10'd0, req_attr_word[12:10]} * COORD_W'(TILE_SIZE));
      span_y = COORD_W'({10'd0, req_attr_word[9:7]} * COORD_W'(TILE_SIZE));
      y_first = y_ext + y_off_ext + (req_attr_word[13] ? span_y : '0);
      base_code = {2'b00, req_tile_word[13:0]};
      if (ext_bank_ff) begin
         base_code[14] = req_attr_word[6];
         base_code[15] = req_y_word[15];
      end
   end

   // sequencer: load an entry, then step through the grid
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      code_in      = code_ff;
      palette_in   = palette_ff;
      flip_x_in    = flip_x_ff;
      flip_y_in    = flip_y_ff;
      pmask_in     = pmask_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      y_start_in   = y_start_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_attr_word[15]) begin
               state_in     = ST_EMIT;
               col_in       = '0;
               row_in       = '0;
               width_m1_in  = req_attr_word[12:10];
               height_m1_in = req_attr_word[9:7];
               code_in      = base_code;
               palette_in   = PALETTE_BASE + {1'b0, req_attr_word[5:0]};
               flip_x_in    = req_attr_word[14];
               flip_y_in    = req_attr_word[13];
               pmask_in     = decode_priority(ext_pri_ff, req_attr_word[6],
                                              req_tile_word[15:14]);
               pos_x_in     = x_ext + x_off_ext + (req_attr_word[14] ? span_x : '0);
               pos_y_in     = y_first;
               y_start_in   = y_first;
            end
         end
         ST_EMIT: begin
            if (rsp_beat) begin
               code_in = code_ff + 16'd1;
               if (cell_last) begin
                  state_in = ST_IDLE;
               end else if (cell_last_row) begin
                  // advance to next column, rewind rows
                  col_in   = col_ff + 3'd1;
                  row_in   = '0;
                  pos_y_in = y_start_ff;
                  pos_x_in = flip_x_ff ? (pos_x_ff - STEP) : (pos_x_ff + STEP);
               end else begin
                  row_in   = row_ff + 3'd1;
                  pos_y_in = flip_y_ff ? (pos_y_ff - STEP) : (pos_y_ff + STEP);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      width_m1_ff  <= width_m1_in;
      height_m1_ff <= height_m1_in;
      code_ff      <= code_in;
      palette_ff   <= palette_in;
      flip_x_ff    <= flip_x_in;
      flip_y_ff    <= flip_y_in;
      pmask_ff     <= pmask_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      y_start_ff   <= y_start_in;
   end

   // register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_pri_ff  <= 1'b0;
         ext_bank_ff <= 1'b1;
         wide_ff     <= 1'b1;
         x_off_ff    <= '0;
         y_off_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EXT_PRIORITY: ext_pri_ff  <= csr_data[0];
            CSR_EXT_BANKING:  ext_bank_ff <= csr_data[0];
            CSR_WIDE_SCREEN:  wide_ff     <= csr_data[0];
            CSR_X_OFFSET:     x_off_ff    <= signed'(csr_data);
            CSR_Y_OFFSET:     y_off_ff    <= signed'(csr_data);
            default: ;
         endcase
      end
   end

   // drive ports from registers
   assign csr_ready         = 1'b1;
   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_EMIT);
   assign rsp_tile_code     = code_ff;
   assign rsp_palette_index = palette_ff;
   assign rsp_flip_x        = flip_x_ff;
   assign rsp_flip_y        = flip_y_ff;
   assign rsp_draw_x        = pos_x_ff;
   assign rsp_draw_y        = pos_y_ff;
   assign rsp_priority_mask = pmask_ff;
   assign rsp_last          = cell_last;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("entry accepted while commands pending");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_last) |=> req_ready)
      else $error("sequencer did not return to idle after last tile");

   a_code_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && !rsp_last) |=> (rsp_valid && rsp_tile_code == $past(rsp_tile_code) + 16'd1))
      else $error("tile code did not advance by one");

   a_grid_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (row_ff <= height_m1_ff && col_ff <= width_m1_ff))
      else $error("grid counters out of range");

   a_disabled_drop: assert property (@(posedge clock) disable iff (reset)
      (req_beat && !req_attr_word[15]) |=> req_ready)
      else $error("disabled entry started emitting");

endmodule

// File: dv/sprite_entry_tile_expander_tb.sv
// Self-checking bench for sprite_entry_tile_expander: a directed plan, then random phases.
// Depends on setx_pkg and the RTL; predicts each tile command and checks the beats in order.
module sprite_entry_tile_expander_tb;
   import setx_pkg::*;

   localparam int TILE_SIZE         = 16;
   localparam int HALF_PERIOD       = 6;
   localparam int RESET_CYCLES      = 11;
   localparam int SETTLE_CYCLES     = 4;
   localparam int STALL_LIMIT       = 2000;
   localparam int LONG_HOLD         = 300;
   localparam int PHASES            = 8;
   localparam int ENTRIES_PER_PHASE = 57;
   localparam int MAX_REPORTS       = 10;

   typedef struct packed {
      logic [15:0]        tile_code;
      logic [6:0]         palette_index;
      logic               flip_x;
      logic               flip_y;
      logic [COORD_W-1:0] draw_x;
      logic [COORD_W-1:0] draw_y;
      logic [15:0]        priority_mask;
      logic               last;
   } tile_cmd_type;

   typedef enum logic [1:0] {
      ROW_ENTRY,   // checked against the predictor
      ROW_LISTED,  // 1x1 entry whose command is written out in the plan
      ROW_CSR      // register write
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [15:0]           attr;
      logic [15:0]           tile;
      logic [15:0]           xw;
      logic [15:0]           yw;
      logic [2:0]            csr_index;
      logic [CSR_DATA_W-1:0] csr_data;
      tile_cmd_type          listed;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_attr_word = '0;
   logic [15:0] req_tile_word = '0;
   logic [15:0] req_x_word = '0;
   logic [15:0] req_y_word = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [15:0]        rsp_tile_code;
   logic [6:0]         rsp_palette_index;
   logic               rsp_flip_x;
   logic               rsp_flip_y;
   logic [COORD_W-1:0] rsp_draw_x;
   logic [COORD_W-1:0] rsp_draw_y;
   logic [15:0]        rsp_priority_mask;
   logic               rsp_last;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [2:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow copy of the registers
   logic                  cfg_ext_priority;
   logic                  cfg_ext_banking;
   logic                  cfg_wide_screen;
   logic signed [9:0]     cfg_x_offset;
   logic signed [9:0]     cfg_y_offset;

   tile_cmd_type tile_cmds_due[$];
   plan_row_type plan[$];

   // entry currently offered carries a written-out command
   bit           listed_on = 1'b0;
   tile_cmd_type listed_cmd = '0;

   bit steady = 1'b0;
   int hold_off_cycles = 0;
   int fail_count = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;

   always #(HALF_PERIOD) clock = ~clock;

   sprite_entry_tile_expander #(
      .TILE_SIZE(TILE_SIZE)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_attr_word    (req_attr_word),
      .req_tile_word    (req_tile_word),
      .req_x_word       (req_x_word),
      .req_y_word       (req_y_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tile_code    (rsp_tile_code),
      .rsp_palette_index(rsp_palette_index),
      .rsp_flip_x       (rsp_flip_x),
      .rsp_flip_y       (rsp_flip_y),
      .rsp_draw_x       (rsp_draw_x),
      .rsp_draw_y       (rsp_draw_y),
      .rsp_priority_mask(rsp_priority_mask),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // expand one sprite entry into its tile commands, column by column
   function automatic void expand_entry(input logic [15:0] attr, input logic [15:0] tword,
                                        input logic [15:0] xw, input logic [15:0] yw);
      tile_cmd_type cmd;
      logic [15:0]  code;
      int           x0, y0, cols, rows, col, row, cx, cy, px, py;
      if (!attr[15])
         return;
      if (!cfg_ext_priority)
         cmd.priority_mask = (&tword[15:14]) ? PRI_MASK_TOP : PRI_MASK_HIGH;
      else if (attr[6])
         cmd.priority_mask = (tword[15:14] == 2'b00) ? PRI_MASK_MID : PRI_MASK_NONE;
      else
         cmd.priority_mask = tword[15] ? PRI_MASK_HIGH : PRI_MASK_LOW;
      code = {2'b00, tword[13:0]};
      if (cfg_ext_banking) begin
         code[14] = attr[6];
         code[15] = yw[15];
      end
      if (cfg_wide_screen) begin
         x0 = int'($signed(xw[11:0]));
         y0 = int'($signed(yw[11:0]));
      end else begin
         x0 = int'($signed(xw[8:0]));
         y0 = int'($signed(yw[8:0]));
      end
      cmd.palette_index = {1'b0, attr[5:0]} + PALETTE_BASE;
      cmd.flip_x = attr[14];
      cmd.flip_y = attr[13];
      cols = int'(attr[12:10]) + 1;
      rows = int'(attr[9:7]) + 1;
      for (col = 0; col < cols; col++) begin
         for (row = 0; row < rows; row++) begin
            // a flip mirrors where the cell lands, not the tile order
            cx = attr[14] ? cols - 1 - col : col;
            cy = attr[13] ? rows - 1 - row : row;
            px = x0 + cx * TILE_SIZE + int'(cfg_x_offset);
            py = y0 + cy * TILE_SIZE + int'(cfg_y_offset);
            cmd.tile_code = code;
            cmd.draw_x = px[COORD_W-1:0];
            cmd.draw_y = py[COORD_W-1:0];
            cmd.last = (col == cols - 1) && (row == rows - 1);
            tile_cmds_due.push_back(cmd);
            code = code + 16'd1;
         end
      end
   endfunction

   function automatic void note_mismatch(input string what, input tile_cmd_type want,
                                         input tile_cmd_type got);
      fail_count++;
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $write("%0t %s: want tile %h pal %h fx %b fy %b x %0d y %0d pri %h last %b",
                $realtime, what,
                want.tile_code, want.palette_index, want.flip_x, want.flip_y,
                $signed(want.draw_x), $signed(want.draw_y), want.priority_mask, want.last);
         $display(" | got tile %h pal %h fx %b fy %b x %0d y %0d pri %h last %b",
                  got.tile_code, got.palette_index, got.flip_x, got.flip_y,
                  $signed(got.draw_x), $signed(got.draw_y), got.priority_mask, got.last);
      end
   endfunction

   // check result beats, predict on entry beats, track register writes
   always @(posedge clock) begin : scoreboard
      tile_cmd_type got;
      tile_cmd_type want;
      if (reset) begin
         cfg_ext_priority <= 1'b0;
         cfg_ext_banking  <= 1'b1;
         cfg_wide_screen  <= 1'b1;
         cfg_x_offset     <= '0;
         cfg_y_offset     <= '0;
         idle_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.tile_code     = rsp_tile_code;
            got.palette_index = rsp_palette_index;
            got.flip_x        = rsp_flip_x;
            got.flip_y        = rsp_flip_y;
            got.draw_x        = rsp_draw_x;
            got.draw_y        = rsp_draw_y;
            got.priority_mask = rsp_priority_mask;
            got.last          = rsp_last;
            if (tile_cmds_due.size() == 0) begin
               note_mismatch("tile command with nothing expected", '0, got);
            end else begin
               want = tile_cmds_due.pop_front();
               if (got.tile_code !== want.tile_code ||
                   got.palette_index !== want.palette_index ||
                   got.flip_x !== want.flip_x || got.flip_y !== want.flip_y ||
                   got.draw_x !== want.draw_x || got.draw_y !== want.draw_y ||
                   got.priority_mask !== want.priority_mask || got.last !== want.last)
                  note_mismatch("tile command mismatch", want, got);
            end
         end
         if (req_valid && req_ready) begin
            if (listed_on)
               tile_cmds_due.push_back(listed_cmd);
            else
               expand_entry(req_attr_word, req_tile_word, req_x_word, req_y_word);
         end
         // indexes past the register list are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EXT_PRIORITY: cfg_ext_priority <= csr_data[0];
               CSR_EXT_BANKING:  cfg_ext_banking  <= csr_data[0];
               CSR_WIDE_SCREEN:  cfg_wide_screen  <= csr_data[0];
               CSR_X_OFFSET:     cfg_x_offset     <= csr_data;
               CSR_Y_OFFSET:     cfg_y_offset     <= csr_data;
               default: ;
            endcase
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t no handshake for %0d cycles, %0d tile commands outstanding",
                     $realtime, STALL_LIMIT, tile_cmds_due.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // result side: random stall per beat, plus one long hold-off on request
   initial begin : result_drain
      int gap;
      @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         gap = steady ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
         @(negedge clock);
      end
   end

   function automatic void add_entry(input logic [15:0] attr, input logic [15:0] tword,
                                     input logic [15:0] xw, input logic [15:0] yw);
      plan_row_type r;
      r = '0;
      r.kind = ROW_ENTRY;
      r.attr = attr;
      r.tile = tword;
      r.xw = xw;
      r.yw = yw;
      plan.push_back(r);
   endfunction

   // single-tile entry without flips, command written out by hand
   function automatic void add_listed(input logic [15:0] attr, input logic [15:0] tword,
                                      input logic [15:0] xw, input logic [15:0] yw,
                                      input logic [15:0] code, input logic [6:0] pal,
                                      input int dx, input int dy, input logic [15:0] pmask);
      plan_row_type r;
      r = '0;
      r.kind = ROW_LISTED;
      r.attr = attr;
      r.tile = tword;
      r.xw = xw;
      r.yw = yw;
      r.listed.tile_code = code;
      r.listed.palette_index = pal;
      r.listed.draw_x = dx[COORD_W-1:0];
      r.listed.draw_y = dy[COORD_W-1:0];
      r.listed.priority_mask = pmask;
      r.listed.last = 1'b1;
      plan.push_back(r);
   endfunction

   function automatic void add_csr(input logic [2:0] index, input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.csr_index = index;
      r.csr_data = data;
      plan.push_back(r);
   endfunction

   // offer one entry beat after a random gap; valid stays up for a back-to-back beat
   task automatic offer_entry(input logic [15:0] attr, input logic [15:0] tword,
                              input logic [15:0] xw, input logic [15:0] yw,
                              input bit listed, input tile_cmd_type cmd);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_attr_word <= attr;
      req_tile_word <= tword;
      req_x_word    <= xw;
      req_y_word    <= yw;
      listed_on  = listed;
      listed_cmd = cmd;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // hold the entry side until every command is out, then let the block settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tile_cmds_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_coord();
      logic [15:0] w;
      w = 16'($urandom);
      // lean on the signed limits of both coordinate widths
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 5))
            0: w[11:0] = 12'h7ff;
            1: w[11:0] = 12'h800;
            2: w[11:0] = 12'hfff;
            3: w[11:0] = 12'h000;
            4: w[11:0] = 12'h0ff;
            default: w[11:0] = 12'h100;
         endcase
      end
      return w;
   endfunction

   initial begin : stimulus
      plan_row_type          r;
      logic [15:0]           attr, tword;
      logic [CSR_DATA_W-1:0] word, x_off, y_off;
      logic [2:0]            spare_index;
      int                    i, p, j;

      // registers at reset: plain priority, banking on, wide screen, no offsets
      add_listed(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'h40, 0, 0, 16'hfffc);
      add_listed(16'h807f, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 7'h7f, -1, -1, 16'hfffe);
      add_listed(16'h8000, 16'h8000, 16'h07ff, 16'h0800, 16'h0000, 7'h40, 2047, -2048, 16'hfffc);
      // full grid, both flips, tile number wraps past 0xffff
      add_entry(16'hffd5, 16'h3ff0, 16'h0f80, 16'h87f0);
      add_entry(16'h9c0a, 16'h1234, 16'h0000, 16'h0000);
      add_entry(16'hc900, 16'h0abc, 16'h0010, 16'h0f00);
      add_entry(16'ha480, 16'h5555, 16'h0ff0, 16'h0020);
      // disabled entries give nothing
      add_entry(16'h7fff, 16'hffff, 16'hffff, 16'hffff);
      add_entry(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      // extended priority: every code of the three-bit decode
      add_csr(CSR_EXT_PRIORITY, 10'h001);
      add_listed(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'h40, 0, 0, 16'hff00);
      add_listed(16'h8000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 7'h40, 0, 0, 16'hff00);
      add_listed(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 7'h40, 0, 0, 16'hfffc);
      add_listed(16'h8000, 16'hc000, 16'h0000, 16'h0000, 16'h0000, 7'h40, 0, 0, 16'hfffc);
      add_listed(16'h8040, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 7'h40, 0, 0, 16'hffe0);
      add_listed(16'h8040, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 7'h40, 0, 0, 16'h0000);
      add_listed(16'h8040, 16'h8000, 16'h0000, 16'h0000, 16'h4000, 7'h40, 0, 0, 16'h0000);
      add_listed(16'h8040, 16'hc000, 16'h0000, 16'h0000, 16'h4000, 7'h40, 0, 0, 16'h0000);
      // narrow screen, no banking, offsets at their limits, writes past the list
      add_csr(CSR_EXT_BANKING, 10'h3fe);
      add_csr(CSR_WIDE_SCREEN, 10'h000);
      add_csr(CSR_X_OFFSET, 10'h200);
      add_csr(CSR_Y_OFFSET, 10'h1ff);
      add_csr(CSR_Y_OFFSET + 3'd1, 10'h3ff);
      add_csr(CSR_Y_OFFSET + 3'd3, 10'h155);
      add_listed(16'h807f, 16'hffff, 16'h0100, 16'h80ff, 16'h3fff, 7'h7f, -768, 766, 16'h0000);
      add_entry(16'h9f80, 16'h2abc, 16'h00ff, 16'hfe00);
      add_csr(CSR_WIDE_SCREEN, 10'h001);
      add_csr(CSR_X_OFFSET, 10'h1ff);
      add_csr(CSR_Y_OFFSET, 10'h200);
      add_entry(16'hffff, 16'h3fff, 16'h07ff, 16'h0800);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // walk the directed plan
      for (i = 0; i < plan.size(); i++) begin
         r = plan[i];
         if (r.kind == ROW_CSR) begin
            if (i == 0 || plan[i-1].kind != ROW_CSR)
               wait_drained();
            write_reg(r.csr_index, r.csr_data);
            if (i + 1 == plan.size() || plan[i+1].kind != ROW_CSR)
               csr_valid <= 1'b0;
         end else begin
            offer_entry(r.attr, r.tile, r.xw, r.yw, r.kind == ROW_LISTED, r.listed);
         end
      end

      // random phases, one register setting each; the mode bits walk all combinations
      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         word = CSR_DATA_W'($urandom);
         word[0] = p[0];
         write_reg(CSR_EXT_PRIORITY, word);
         word = CSR_DATA_W'($urandom);
         word[0] = p[1];
         write_reg(CSR_EXT_BANKING, word);
         word = CSR_DATA_W'($urandom);
         word[0] = p[2];
         write_reg(CSR_WIDE_SCREEN, word);
         case (p)
            0: begin x_off = 10'h200; y_off = 10'h1ff; end
            1: begin x_off = 10'h1ff; y_off = 10'h200; end
            2: begin x_off = 10'h000; y_off = 10'h000; end
            default: begin
               x_off = CSR_DATA_W'($urandom);
               y_off = CSR_DATA_W'($urandom);
            end
         endcase
         write_reg(CSR_X_OFFSET, x_off);
         write_reg(CSR_Y_OFFSET, y_off);
         spare_index = CSR_Y_OFFSET + 3'd1 + 3'(p % 3);
         write_reg(spare_index, CSR_DATA_W'($urandom));
         csr_valid <= 1'b0;

         for (j = 0; j < ENTRIES_PER_PHASE; j++) begin
            steady = (j >= 20 && j < 32);
            // stall the result side long enough that the entry side backs up
            if (p == 3 && j == 5)
               hold_off_cycles = LONG_HOLD;
            if (j == 40)
               wait_drained();
            attr = 16'($urandom);
            attr[15] = ($urandom_range(0, 9) != 0);
            tword = 16'($urandom);
            if ($urandom_range(0, 7) == 0)
               tword[13:6] = '1;
            offer_entry(attr, tword, pick_coord(), pick_coord(), 1'b0, '0);
         end
         steady = 1'b0;
      end

      wait_drained();
      repeat (4 * SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && tile_cmds_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/setx_pkg.sv
rtl/sprite_entry_tile_expander.sv
dv/sprite_entry_tile_expander_tb.sv
